// ===== hdl/smd_pkg.sv =====
// ============================================================================
// smd_pkg: shared types and constants of the sparse memory image decoder
// Holds the bitmap store geometry, the result codes and the beat types that
// pass between the decoder modules.
// ============================================================================
package smd_pkg;

    localparam int MAP_BYTES  = 1024;
    localparam int MAP_ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int MAP_LEN_W  = $clog2(MAP_BYTES + 1);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_SIZE,
        PH_MAP,
        PH_SEEK_RD,
        PH_SEEK_CHK,
        PH_DATA,
        PH_HALT
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] wr_addr;
        logic [63:0] wr_data;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

// ===== hdl/smd_if.sv =====
// ============================================================================
// smd_if: stream interfaces of the sparse memory image decoder
// One interface for the raw byte stream and one for the decoded results,
// each with valid, ready and its payload.
// ============================================================================
interface smd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface smd_out_if;
    import smd_pkg::*;

    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [63:0] wr_addr;
    logic [63:0] wr_data;

    modport source (output valid, output kind, output wr_addr, output wr_data, input ready);
    modport sink (input valid, input kind, input wr_addr, input wr_data, output ready);
endinterface

// ===== hdl/sparse_memory_image_decoder_unit.sv =====
// A result is registered and shown in the cycle after the beat that completes it.
// Throughput: one input beat per cycle in every field while the output register is free.
// After the bitmap field and after each data word, the bit search passes a read state
// and a check state per bitmap byte it reads; no beat is taken meanwhile.
// Reset: synchronous, active low; after an end or error result the unit
// discards input until reset.
// ============================================================================
// sparse_memory_image_decoder_unit: sparse memory image decoder, top level
// Turns a byte stream of sparse image records into 64-bit memory writes.
// ============================================================================
module sparse_memory_image_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smd_in_if.sink    i_in,
    smd_out_if.source o_out
);
    import smd_pkg::*;

    t_push push;
    logic  out_free;

    smd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_byte     (i_in.in_byte),
        .o_ready    (i_in.ready),
        .i_out_free (out_free),
        .o_push     (push)
    );

    smd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_push_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> out_free)
        else $error("result loaded while the output register is occupied");

    a_status_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind != KIND_WRITE)) |->
        ((o_out.wr_addr == '0) && (o_out.wr_data == '0)))
        else $error("end or error result carries address or data");

    a_silent_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.valid && (push.res.kind != KIND_WRITE)) |=> !push.valid)
        else $error("result produced after end of image or error");
`endif
endmodule

// ===== hdl/smd_ram.sv =====
// ============================================================================
// smd_ram: generic single-port synchronous RAM
// One address per cycle; a write also reads out the old word, and the read data is registered.
// ============================================================================
module smd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/smd_ctrl.sv =====
// ============================================================================
// smd_ctrl: record parser and bitmap sequencer
// Collects address, size, bitmap and data fields from the byte stream, keeps
// the bitmap in a RAM and walks it one byte at a time to find set bits.
// ============================================================================
module smd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    input  logic          i_out_free,
    output smd_pkg::t_push o_push
);
    import smd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_biw, n_biw;
    logic [63:0]            r_base, n_base;
    logic [63:0]            r_size, n_size;
    logic [MAP_LEN_W-1:0]   r_map_len, n_map_len;
    logic [MAP_LEN_W-1:0]   r_scan_byte, n_scan_byte;
    logic [2:0]             r_scan_bit, n_scan_bit;
    logic [63:0]            r_data, n_data;

    logic                   accept;
    logic                   last;
    logic                   ram_we;
    logic [7:0]             ram_rdata;
    logic [7:0]             masked;
    logic [2:0]             low_bit;
    logic [MAP_LEN_W-1:0]   next_byte;
    logic [57:0]            len;

    smd_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_scan_byte[MAP_ADDR_W-1:0]),
        .i_wdata (i_byte),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ADDR;
            r_biw       <= '0;
            r_map_len   <= '0;
            r_scan_byte <= '0;
            r_scan_bit  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_biw       <= n_biw;
            r_map_len   <= n_map_len;
            r_scan_byte <= n_scan_byte;
            r_scan_bit  <= n_scan_bit;
        end
        r_base <= n_base;
        r_size <= n_size;
        r_data <= n_data;
    end

    always_comb begin
        masked  = ram_rdata & (8'hFF << r_scan_bit);
        low_bit = '0;
        for (int i = 7; i >= 0; i--) begin
            if (masked[i]) begin
                low_bit = 3'(i);
            end
        end
    end

    assign o_ready   = (r_phase inside {PH_ADDR, PH_SIZE, PH_MAP, PH_DATA, PH_HALT})
                       && i_out_free;
    assign accept    = i_valid && o_ready;
    assign last      = (r_biw == 3'd7);
    assign next_byte = r_scan_byte + MAP_LEN_W'(1);
    assign len       = n_size[63:6];

    always_comb begin
        n_phase     = r_phase;
        n_biw       = r_biw;
        n_base      = r_base;
        n_size      = r_size;
        n_map_len   = r_map_len;
        n_scan_byte = r_scan_byte;
        n_scan_bit  = r_scan_bit;
        n_data      = r_data;
        ram_we      = 1'b0;
        o_push      = '0;

        case (r_phase)
            PH_ADDR: begin
                if (accept) begin
                    n_base = {i_byte, r_base[63:8]};
                    n_biw  = r_biw + 3'd1;
                    if (last) begin
                        if (n_base == '0) begin
                            n_phase         = PH_HALT;
                            o_push.valid    = 1'b1;
                            o_push.res.kind = KIND_END;
                        end else begin
                            n_phase = PH_SIZE;
                        end
                    end
                end
            end
            PH_SIZE: begin
                if (accept) begin
                    n_size = {i_byte, r_size[63:8]};
                    n_biw  = r_biw + 3'd1;
                    if (last) begin
                        if (len > 58'(MAP_BYTES)) begin
                            n_phase         = PH_HALT;
                            o_push.valid    = 1'b1;
                            o_push.res.kind = KIND_ERROR;
                        end else begin
                            n_map_len   = len[MAP_LEN_W-1:0];
                            n_scan_byte = '0;
                            n_scan_bit  = '0;
                            n_phase     = (len == '0) ? PH_ADDR : PH_MAP;
                        end
                    end
                end
            end
            PH_MAP: begin
                if (accept) begin
                    ram_we      = 1'b1;
                    n_scan_byte = next_byte;
                    if (next_byte >= r_map_len) begin
                        n_scan_byte = '0;
                        n_scan_bit  = '0;
                        n_biw       = '0;
                        n_phase     = PH_SEEK_RD;
                    end
                end
            end
            PH_SEEK_RD: begin
                n_phase = PH_SEEK_CHK;
            end
            PH_SEEK_CHK: begin
                if (|masked) begin
                    n_scan_bit = low_bit;
                    n_phase    = PH_DATA;
                end else if (next_byte >= r_map_len) begin
                    n_phase = PH_ADDR;
                end else begin
                    n_scan_byte = next_byte;
                    n_scan_bit  = '0;
                    n_phase     = PH_SEEK_RD;
                end
            end
            PH_DATA: begin
                if (accept) begin
                    n_data = {i_byte, r_data[63:8]};
                    n_biw  = r_biw + 3'd1;
                    if (last) begin
                        o_push.valid       = 1'b1;
                        o_push.res.kind    = KIND_WRITE;
                        o_push.res.wr_addr = r_base + 64'({r_scan_byte, r_scan_bit, 3'b000});
                        o_push.res.wr_data = n_data;
                        if (r_scan_bit == 3'd7) begin
                            n_scan_bit = '0;
                            if (next_byte >= r_map_len) begin
                                n_phase = PH_ADDR;
                            end else begin
                                n_scan_byte = next_byte;
                                n_phase     = PH_SEEK_RD;
                            end
                        end else begin
                            n_scan_bit = r_scan_bit + 3'd1;
                            n_phase    = PH_SEEK_RD;
                        end
                    end
                end
            end
            PH_HALT: begin
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end
endmodule

// ===== hdl/smd_out_reg.sv =====
// ============================================================================
// smd_out_reg: result output register
// Holds one decoded result until the sink takes it and tells the parser
// whether a new result can be loaded in this cycle.
// ============================================================================
module smd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smd_pkg::t_push   i_push,
    output logic             o_free,
    smd_out_if.source        o_out
);
    import smd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (i_push.valid) begin
            r_res <= i_push.res;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.kind    = r_res.kind;
    assign o_out.wr_addr = r_res.wr_addr;
    assign o_out.wr_data = r_res.wr_data;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the sparse memory image decoder unit
// Streams sparse image records into the decoder with random bursts and
// gaps, stalls the result side, and checks every result beat field by field
// against a decoder model kept in the testbench. The image is closed by an
// end record or an oversized bitmap, chosen at random, then padded with
// bytes that the halted unit must drop.
// ============================================================================
module tb_top;
    import smd_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;
    localparam int LONG_MAP   = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    smd_in_if  in_if ();
    smd_out_if out_if ();

    sparse_memory_image_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [7:0] stream_bytes[$];
    t_result    expected_writes[$];
    int         mismatch_count  = 0;
    int         results_checked = 0;
    int         bytes_queued    = 0;
    int         writes_queued   = 0;
    int         burst_left      = 1;
    int         gap_left        = 0;
    int         hold_left       = 0;
    bit         long_hold_done  = 1'b0;
    int         rx_cycle        = 0;
    int         rx_mode         = 0;
    int         idle_cycles     = 0;

    t_phase               dec_phase;
    logic [2:0]           dec_byte_cnt;
    logic [63:0]          dec_base;
    logic [63:0]          dec_size;
    logic [63:0]          dec_data;
    logic [MAP_LEN_W-1:0] dec_map_len;
    logic [MAP_LEN_W-1:0] dec_scan_byte;
    logic [3:0]           dec_scan_bit;
    logic [7:0]           dec_map [MAP_BYTES];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit find_set_bit();
        while (dec_scan_byte < dec_map_len) begin
            while (dec_scan_bit < 4'd8) begin
                if (dec_map[dec_scan_byte][dec_scan_bit[2:0]]) begin
                    return 1'b1;
                end
                dec_scan_bit++;
            end
            dec_scan_bit = '0;
            dec_scan_byte++;
        end
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic    last;
        t_result res;
        last        = (dec_byte_cnt == 3'd7);
        res.kind    = KIND_WRITE;
        res.wr_addr = '0;
        res.wr_data = '0;
        case (dec_phase)
            PH_ADDR: begin
                dec_base = {b, dec_base[63:8]};
                dec_byte_cnt++;
                if (last) begin
                    if (dec_base == '0) begin
                        dec_phase = PH_HALT;
                        res.kind  = KIND_END;
                        expected_writes.push_back(res);
                    end else begin
                        dec_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                dec_size = {b, dec_size[63:8]};
                dec_byte_cnt++;
                if (last) begin
                    if (dec_size[63:6] > 58'(MAP_BYTES)) begin
                        dec_phase = PH_HALT;
                        res.kind  = KIND_ERROR;
                        expected_writes.push_back(res);
                    end else begin
                        dec_map_len   = dec_size[6 +: MAP_LEN_W];
                        dec_scan_byte = '0;
                        dec_scan_bit  = '0;
                        dec_phase     = (dec_map_len == '0) ? PH_ADDR : PH_MAP;
                    end
                end
            end
            PH_MAP: begin
                dec_map[dec_scan_byte] = b;
                dec_scan_byte++;
                if (dec_scan_byte >= dec_map_len) begin
                    dec_scan_byte = '0;
                    dec_scan_bit  = '0;
                    dec_data      = '0;
                    dec_byte_cnt  = '0;
                    dec_phase     = find_set_bit() ? PH_DATA : PH_ADDR;
                end
            end
            PH_DATA: begin
                dec_data = {b, dec_data[63:8]};
                dec_byte_cnt++;
                if (last) begin
                    res.wr_addr = dec_base + (64'(dec_scan_byte) << 6)
                                + (64'(dec_scan_bit) << 3);
                    res.wr_data = dec_data;
                    expected_writes.push_back(res);
                    dec_data = '0;
                    dec_scan_bit++;
                    dec_phase = find_set_bit() ? PH_DATA : PH_ADDR;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_word(input logic [63:0] w);
        for (int i = 0; i < 8; i++) begin
            stream_bytes.push_back(w[8*i +: 8]);
        end
        bytes_queued += 8;
    endtask

    task automatic add_record(input logic [63:0] base, input logic [63:0] size,
                              input logic [7:0] map_bytes[$]);
        logic [63:0] word;
        push_word(base);
        push_word(size);
        foreach (map_bytes[i]) begin
            stream_bytes.push_back(map_bytes[i]);
            bytes_queued++;
        end
        foreach (map_bytes[i]) begin
            repeat ($countones(map_bytes[i])) begin
                case ($urandom_range(0, 5))
                    0:       word = '1;
                    1:       word = '0;
                    default: word = {$urandom, $urandom};
                endcase
                push_word(word);
                writes_queued++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.in_byte <= '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                void'(stream_bytes.pop_front());
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    in_if.valid <= 1'b0;
                    gap_left--;
                end else if (stream_bytes.size() != 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.in_byte <= stream_bytes[0];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else if (!long_hold_done && results_checked >= 30) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0) begin
                rx_mode = $urandom_range(0, 2);
            end
            rx_cycle++;
            case (rx_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                default: out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            dec_phase     = PH_ADDR;
            dec_byte_cnt  = '0;
            dec_base      = '0;
            dec_size      = '0;
            dec_data      = '0;
            dec_map_len   = '0;
            dec_scan_byte = '0;
            dec_scan_bit  = '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.in_byte);
            end
            if (out_if.valid && out_if.ready) begin
                results_checked++;
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected result beat kind %0d addr %h data %h",
                             $time, out_if.kind, out_if.wr_addr, out_if.wr_data);
                    mismatch_count++;
                end else begin
                    want = expected_writes.pop_front();
                    if (out_if.kind !== want.kind) begin
                        $display("%0t: kind expected %0d, actual %0d",
                                 $time, want.kind, out_if.kind);
                        mismatch_count++;
                    end
                    if (out_if.wr_addr !== want.wr_addr) begin
                        $display("%0t: wr_addr expected %h, actual %h",
                                 $time, want.wr_addr, out_if.wr_addr);
                        mismatch_count++;
                    end
                    if (out_if.wr_data !== want.wr_data) begin
                        $display("%0t: wr_data expected %h, actual %h",
                                 $time, want.wr_data, out_if.wr_data);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sparse_memory_image_decoder_unit test failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] base;
        logic [7:0]  map_bytes[$];
        int          len;
        int          pick;
        int          style;
        int          start_bytes;
        int          start_writes;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        map_bytes = '{8'hFF, 8'h5A};
        add_record(64'h0000_0000_0000_1000, 64'd191, map_bytes);
        map_bytes = '{8'h81, 8'h80};
        add_record(64'hFFFF_FFFF_FFFF_FFC8, 64'd128, map_bytes);
        map_bytes.delete();
        add_record(64'h8000_0000_0000_0000, 64'd63, map_bytes);
        map_bytes = '{8'h00, 8'h00, 8'h00};
        add_record(64'h0000_0000_0000_0001, 64'd255, map_bytes);
        map_bytes.delete();
        repeat (LONG_MAP) map_bytes.push_back(8'h00);
        map_bytes[0]            = 8'h01;
        map_bytes[LONG_MAP / 2] = 8'h10;
        map_bytes[LONG_MAP - 1] = 8'h80;
        add_record(64'h0123_4567_89AB_CDC0, (64'(LONG_MAP) << 6) | 64'd63, map_bytes);

        while (results_checked < writes_queued) begin
            @(posedge i_clk);
        end

        start_bytes  = bytes_queued;
        start_writes = writes_queued;
        while (bytes_queued - start_bytes < 130 || writes_queued - start_writes < 8) begin
            case ($urandom_range(0, 3))
                0:       base = {$urandom, $urandom};
                1:       base = 64'hFFFF_FFFF_FFFF_FC00 | 64'($urandom_range(0, 1023));
                default: base = 64'($urandom_range(0, 32'hFFFF)) << 6;
            endcase
            if (base == '0) begin
                base = 64'h40;
            end
            pick  = $urandom_range(0, 19);
            len   = (pick == 0) ? 0 : (pick < 17) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            style = $urandom_range(0, 3);
            map_bytes.delete();
            repeat (len) begin
                case (style)
                    0:       map_bytes.push_back(8'h00);
                    1:       map_bytes.push_back((len <= 3) ? 8'hFF
                                                 : 8'(1 << $urandom_range(0, 7)));
                    2:       map_bytes.push_back(8'(1 << $urandom_range(0, 7)));
                    default: map_bytes.push_back(8'($urandom));
                endcase
            end
            add_record(base, (64'(len) << 6) | 64'($urandom_range(0, 63)), map_bytes);
        end

        map_bytes.delete();
        case ($urandom_range(0, 2))
            0:       push_word('0);
            1:       add_record({$urandom, $urandom} | 64'h1,
                                (64'(MAP_BYTES) + 64'd1) << 6, map_bytes);
            default: add_record({$urandom, $urandom} | 64'h1,
                                {$urandom | 32'h8000_0000, $urandom}, map_bytes);
        endcase
        repeat (8) stream_bytes.push_back(8'($urandom));

        while (stream_bytes.size() != 0 || expected_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sparse_memory_image_decoder_unit test passed");
        end else begin
            $display("sparse_memory_image_decoder_unit test failed");
        end
        $finish;
    end

endmodule
